// ===== rtl/pcrl_pkg.sv =====
// Shared widths, codes and control types of the per-ID cooldown rate limiter.
package pcrl_pkg;

    localparam int NUM_IDS_DEF = 1024;

    localparam int ACT_W   = 3;
    localparam int ID_W    = 10;
    localparam int TIME_W  = 32;
    localparam int LIM_W   = 8;
    localparam int CNT_W   = 8;
    localparam int TOT_W   = 32;
    localparam int FSTAT_W = 16;
    localparam int CAUSE_W = 2;

    localparam logic [FSTAT_W-1:0] OVERLOAD_REQUESTS = 16'd10;
    localparam logic [FSTAT_W-1:0] OVERLOAD_REFUSALS = 16'd5;
    localparam logic [CNT_W-1:0]   CNT_MAX           = '1;
    localparam logic [FSTAT_W-1:0] FSTAT_MAX         = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_REQUEST      = 3'd0,
        ACT_PLAYED       = 3'd1,
        ACT_FRAME_TICK   = 3'd2,
        ACT_CONFIGURE    = 3'd3,
        ACT_CLEAR_TOTALS = 3'd4
    } t_action;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_COOLDOWN = 2'd1,
        CAUSE_LIMIT    = 2'd2
    } t_cause;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic clear_step;
        logic sweep_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic is_tick;
    } t_sts;

    // One word of the configuration table.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] cooldown;
        logic [LIM_W-1:0]  limit;
    } t_entry_cfg;

endpackage

// ===== rtl/pcrl_ifs.sv =====
// Request and response channel interfaces of the rate limiter.
interface pcrl_req_if;
    import pcrl_pkg::*;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    event_id;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  new_cooldown_ms;
    logic [LIM_W-1:0]   new_frame_limit;

    modport source (output valid, action, event_id, now_ms, new_cooldown_ms,
                    new_frame_limit, input ready);
    modport sink (input valid, action, event_id, now_ms, new_cooldown_ms,
                  new_frame_limit, output ready);
endinterface

interface pcrl_rsp_if;
    import pcrl_pkg::*;
    logic               valid;
    logic               ready;
    logic               allowed;
    logic [CAUSE_W-1:0] block_cause;
    logic [TOT_W-1:0]   total_requested;
    logic [TOT_W-1:0]   total_played;
    logic [TOT_W-1:0]   total_blocked;
    logic               overloaded;
    logic [TOT_W-1:0]   frame_number;

    modport source (output valid, allowed, block_cause, total_requested, total_played,
                    total_blocked, overloaded, frame_number, input ready);
    modport sink (input valid, allowed, block_cause, total_requested, total_played,
                  total_blocked, overloaded, frame_number, output ready);
endinterface

// ===== rtl/pcrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcrl_ctrl.sv =====
// Controller state machine: table clearing, item sequencing and result handoff.
module pcrl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output pcrl_pkg::t_cmd o_cmd,
    input  pcrl_pkg::t_sts i_sts
);
    import pcrl_pkg::*;

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SWEEP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   fire;

    // Next state and commands. An item executes once the result register is free.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        fire       = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                fire      = !r_out_valid || i_out_ready;
                o_cmd.exec = fire;
                if (fire) begin
                    n_state = i_sts.is_tick ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || fire;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/pcrl_dp.sv =====
// Datapath: ID tables, admission decision, frame metrics and running totals.
module pcrl_dp #(
    parameter int NUM_IDS = pcrl_pkg::NUM_IDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  pcrl_pkg::t_cmd                 i_cmd,
    output pcrl_pkg::t_sts                 o_sts,
    input  logic [pcrl_pkg::ACT_W-1:0]     i_action,
    input  logic [pcrl_pkg::ID_W-1:0]      i_event_id,
    input  logic [pcrl_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [pcrl_pkg::TIME_W-1:0]    i_new_cooldown_ms,
    input  logic [pcrl_pkg::LIM_W-1:0]     i_new_frame_limit,
    output logic                           o_allowed,
    output logic [pcrl_pkg::CAUSE_W-1:0]   o_block_cause,
    output logic [pcrl_pkg::TOT_W-1:0]     o_total_requested,
    output logic [pcrl_pkg::TOT_W-1:0]     o_total_played,
    output logic [pcrl_pkg::TOT_W-1:0]     o_total_blocked,
    output logic                           o_overloaded,
    output logic [pcrl_pkg::TOT_W-1:0]     o_frame_number
);
    import pcrl_pkg::*;

    localparam int                ADDR_W    = $clog2(NUM_IDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_IDS - 1);
    localparam logic [31:0]       NUM_IDS_W = 32'(NUM_IDS);
    localparam int                CFG_W     = $bits(t_entry_cfg);

    // Configuration register.
    logic r_enable;

    // Captured item.
    logic [ACT_W-1:0]  r_action;
    logic              r_in_range;
    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_cd;
    logic [LIM_W-1:0]  r_lim;

    // Sweep address for the reset clear and the frame count clear.
    logic [ADDR_W-1:0] r_sweep_addr, n_sweep_addr;

    // Running state and result fields.
    logic [TOT_W-1:0]   r_tot_req, n_tot_req;
    logic [TOT_W-1:0]   r_tot_play, n_tot_play;
    logic [TOT_W-1:0]   r_tot_blk, n_tot_blk;
    logic [FSTAT_W-1:0] r_frame_req, n_frame_req;
    logic [FSTAT_W-1:0] r_frame_ref, n_frame_ref;
    logic               r_overload, n_overload;
    logic [TOT_W-1:0]   r_frame_num, n_frame_num;
    logic               r_allowed, n_allowed;
    t_cause             r_cause, n_cause;

    // Table ports.
    logic [31:0]       id_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              cfg_we, last_we, cnt_we;
    t_entry_cfg        cfg_wd, ent;
    logic [CFG_W-1:0]  cfg_rdata;
    logic [TIME_W-1:0] last_wd, last_rdata;
    logic [CNT_W-1:0]  cnt_wd, cnt_rdata;
    logic              valid_e;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  cnt_inc;
    logic [FSTAT_W-1:0] frame_req_inc, frame_ref_inc;

    assign id_ext  = 32'(i_event_id);
    assign rd_addr = id_ext[ADDR_W-1:0];

    pcrl_ram #(.WIDTH(CFG_W), .DEPTH(NUM_IDS)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (wr_addr),
        .i_wdata (cfg_wd),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (cfg_rdata)
    );

    pcrl_ram #(.WIDTH(TIME_W), .DEPTH(NUM_IDS)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (last_we),
        .i_waddr (wr_addr),
        .i_wdata (last_wd),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (last_rdata)
    );

    pcrl_ram #(.WIDTH(CNT_W), .DEPTH(NUM_IDS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (wr_addr),
        .i_wdata (cnt_wd),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    // Decision terms from the entry read at accept time.
    assign ent           = t_entry_cfg'(cfg_rdata);
    assign valid_e       = r_in_range && ent.valid;
    assign elapsed       = r_now - last_rdata;
    assign cnt_inc       = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
    assign frame_req_inc = (r_frame_req == FSTAT_MAX) ? r_frame_req : r_frame_req + 1'b1;
    assign frame_ref_inc = (r_frame_ref == FSTAT_MAX) ? r_frame_ref : r_frame_ref + 1'b1;

    // Execution of one item, plus the table writes of the clearing sweeps.
    always_comb begin
        n_tot_req   = r_tot_req;
        n_tot_play  = r_tot_play;
        n_tot_blk   = r_tot_blk;
        n_frame_req = r_frame_req;
        n_frame_ref = r_frame_ref;
        n_overload  = r_overload;
        n_frame_num = r_frame_num;
        n_allowed   = r_allowed;
        n_cause     = r_cause;
        cfg_we      = 1'b0;
        cfg_wd      = '0;
        last_we     = 1'b0;
        last_wd     = '0;
        cnt_we      = 1'b0;
        cnt_wd      = '0;
        if (i_cmd.exec) begin
            n_allowed = 1'b0;
            n_cause   = CAUSE_NONE;
            case (t_action'(r_action))
                ACT_REQUEST: begin
                    if (!r_enable) begin
                        n_allowed = 1'b1;
                    end else begin
                        n_tot_req   = r_tot_req + 1'b1;
                        n_frame_req = frame_req_inc;
                        if (valid_e && (elapsed < ent.cooldown)) begin
                            n_cause = CAUSE_COOLDOWN;
                        end else if (valid_e && (cnt_rdata >= ent.limit)) begin
                            n_cause = CAUSE_LIMIT;
                        end else begin
                            n_tot_play = r_tot_play + 1'b1;
                            n_allowed  = 1'b1;
                        end
                        if (valid_e && ((elapsed < ent.cooldown) ||
                                        (cnt_rdata >= ent.limit))) begin
                            n_tot_blk   = r_tot_blk + 1'b1;
                            n_frame_ref = frame_ref_inc;
                        end
                    end
                end
                ACT_PLAYED: begin
                    if (r_enable && valid_e) begin
                        last_we = 1'b1;
                        last_wd = r_now;
                        cnt_we  = 1'b1;
                        cnt_wd  = cnt_inc;
                    end
                end
                ACT_FRAME_TICK: begin
                    n_frame_num = r_frame_num + 1'b1;
                    n_overload  = (r_frame_req > OVERLOAD_REQUESTS) ||
                                  (r_frame_ref > OVERLOAD_REFUSALS);
                    n_frame_req = '0;
                    n_frame_ref = '0;
                end
                ACT_CONFIGURE: begin
                    if (r_in_range) begin
                        cfg_we          = 1'b1;
                        cfg_wd.valid    = 1'b1;
                        cfg_wd.cooldown = r_cd;
                        cfg_wd.limit    = r_lim;
                        last_we         = 1'b1;
                        cnt_we          = 1'b1;
                    end
                end
                ACT_CLEAR_TOTALS: begin
                    n_tot_req  = '0;
                    n_tot_play = '0;
                    n_tot_blk  = '0;
                end
                default: begin
                end
            endcase
        end
        // Reset clear wipes the valid bits and counts; the frame sweep wipes counts.
        if (i_cmd.clear_step) begin
            cfg_we = 1'b1;
            cfg_wd = '0;
        end
        if (i_cmd.clear_step || i_cmd.sweep_step) begin
            cnt_we = 1'b1;
            cnt_wd = '0;
        end
    end

    assign wr_addr = (i_cmd.clear_step || i_cmd.sweep_step) ? r_sweep_addr : r_addr;

    // Sweep address walks the whole table and wraps.
    always_comb begin
        n_sweep_addr = r_sweep_addr;
        if (i_cmd.clear_step || i_cmd.sweep_step) begin
            n_sweep_addr = (r_sweep_addr == LAST_ADDR) ? '0 : r_sweep_addr + 1'b1;
        end
    end

    assign o_sts.sweep_last = (r_sweep_addr == LAST_ADDR);
    assign o_sts.is_tick    = (r_action == ACT_FRAME_TICK);

    // Control and running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_sweep_addr <= '0;
            r_tot_req    <= '0;
            r_tot_play   <= '0;
            r_tot_blk    <= '0;
            r_frame_req  <= '0;
            r_frame_ref  <= '0;
            r_overload   <= 1'b0;
            r_frame_num  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            r_sweep_addr <= n_sweep_addr;
            r_tot_req    <= n_tot_req;
            r_tot_play   <= n_tot_play;
            r_tot_blk    <= n_tot_blk;
            r_frame_req  <= n_frame_req;
            r_frame_ref  <= n_frame_ref;
            r_overload   <= n_overload;
            r_frame_num  <= n_frame_num;
        end
    end

    // Item capture and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_action;
            r_in_range <= (id_ext < NUM_IDS_W);
            r_addr     <= rd_addr;
            r_now      <= i_now_ms;
            r_cd       <= i_new_cooldown_ms;
            r_lim      <= i_new_frame_limit;
        end
        r_allowed <= n_allowed;
        r_cause   <= n_cause;
    end

    assign o_allowed         = r_allowed;
    assign o_block_cause     = r_cause;
    assign o_total_requested = r_tot_req;
    assign o_total_played    = r_tot_play;
    assign o_total_blocked   = r_tot_blk;
    assign o_overloaded      = r_overload;
    assign o_frame_number    = r_frame_num;

endmodule

// ===== rtl/per_id_cooldown_rate_limiter_top.sv =====
// Top level of the per-ID cooldown and burst rate limiter.
//
//   Channel   Direction  Handshake       Carries
//   i_req     in         valid/ready     action, event_id, now_ms, new_cooldown_ms,
//                                        new_frame_limit
//   o_rsp     out        valid/ready     allowed, block_cause, three totals,
//                                        overloaded, frame_number
//   i_cfg     in         write enable    throttle_enable (one bit)
//
// Per item, the accept cycle reads the ID tables; the execute state then decides,
// writes the tables back and loads the result register once it is free.
// A frame tick starts a sweep of all NUM_IDS entries that clears the frame counts.
// After reset a clearing pass over all NUM_IDS entries wipes valid bits and counts;
// no item is accepted during it. A new item is taken while a result waits; it
// completes once the result register is free.
module per_id_cooldown_rate_limiter_top #(
    parameter int NUM_IDS = pcrl_pkg::NUM_IDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    pcrl_req_if.sink    i_req,
    pcrl_rsp_if.source  o_rsp
);
    import pcrl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pcrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pcrl_dp #(.NUM_IDS(NUM_IDS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_req.action),
        .i_event_id        (i_req.event_id),
        .i_now_ms          (i_req.now_ms),
        .i_new_cooldown_ms (i_req.new_cooldown_ms),
        .i_new_frame_limit (i_req.new_frame_limit),
        .o_allowed         (o_rsp.allowed),
        .o_block_cause     (o_rsp.block_cause),
        .o_total_requested (o_rsp.total_requested),
        .o_total_played    (o_rsp.total_played),
        .o_total_blocked   (o_rsp.total_blocked),
        .o_overloaded      (o_rsp.overloaded),
        .o_frame_number    (o_rsp.frame_number)
    );

endmodule

// ===== rtl/pcrl_chk.sv =====
// Port-level checker for the rate limiter and its bind to the top level.
module pcrl_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_allowed,
    input logic [pcrl_pkg::CAUSE_W-1:0] i_rsp_block_cause,
    input logic [pcrl_pkg::TOT_W-1:0]   i_rsp_frame_number
);
    import pcrl_pkg::*;

    logic in_acc;
    assign in_acc = i_req_valid && i_req_ready;

    // Items are never accepted back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("input item accepted on two consecutive edges");

    // A fresh result only rises after an item was taken and executed.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(in_acc, 2))
        else $error("result appeared without an item accepted two cycles earlier");

    // A stalled result holds its fields.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_allowed) &&
            $stable(i_rsp_block_cause) && $stable(i_rsp_frame_number))
        else $error("stalled result changed or was dropped");

    // The frame number only moves when a new result is presented.
    a_frame_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(i_rsp_frame_number) && $past(i_rst_n) |-> i_rsp_valid)
        else $error("frame number changed with no result shown");

endmodule

bind per_id_cooldown_rate_limiter_top pcrl_chk u_pcrl_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_allowed      (o_rsp.allowed),
    .i_rsp_block_cause  (o_rsp.block_cause),
    .i_rsp_frame_number (o_rsp.frame_number)
);
